FILE: design/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SAL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SAL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SAL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/sal_pkg.sv
// Shared types and constants of the shelf atlas allocator.
// No dependencies.
package sal_pkg;

   localparam int SIDE_LIMIT = 16384;
   localparam int SIDE_W     = 15;
   localparam int POS_W      = 14;
   localparam int RECT_W     = 14;
   localparam int PAD_W      = 8;
   localparam int CFG_W      = 14;
   localparam int IDX_W      = 2;
   localparam int MIN_SIDE   = 16;

   localparam logic [IDX_W-1:0] CSR_PADDING      = 2'd0;
   localparam logic [IDX_W-1:0] CSR_INITIAL_SIDE = 2'd1;
   localparam logic [IDX_W-1:0] CSR_MAX_SIDE     = 2'd2;

   localparam logic [PAD_W-1:0]  PADDING_RST = 8'd1;
   localparam logic [CFG_W-1:0]  INIT_RST    = 14'd256;
   localparam logic [CFG_W-1:0]  MAX_RST     = 14'd4096;
   localparam logic [SIDE_W-1:0] SIDE_RST    = 15'd256;

   localparam logic [SIDE_W-1:0] LIMIT_V = SIDE_W'(SIDE_LIMIT);
   localparam logic [SIDE_W-1:0] MIN_V   = SIDE_W'(MIN_SIDE);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WORK,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic load;
      logic restart;
      logic place;
      logic new_shelf;
      logic grow;
      logic fail;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic is_restart;
      logic fits;
      logic shelf_ok;
      logic grow_ok;
   } status_type;

   function automatic logic [SIDE_W-1:0] doubled(input logic [SIDE_W-1:0] s);
      logic [SIDE_W:0] d;
      d = {s, 1'b0};
      return (d > {1'b0, LIMIT_V}) ? LIMIT_V : d[SIDE_W-1:0];
   endfunction

endpackage

FILE: design/sal_channels.sv
// Handshake interfaces for the request, response and register channels.
// Depends on sal_pkg.
interface sal_req_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [sal_pkg::RECT_W-1:0]   rect_w;
   logic [sal_pkg::RECT_W-1:0]   rect_h;
   modport source (output valid, kind, rect_w, rect_h, input ready);
   modport sink (input valid, kind, rect_w, rect_h, output ready);
endinterface

interface sal_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         placed;
   logic [sal_pkg::POS_W-1:0]    pos_x;
   logic [sal_pkg::POS_W-1:0]    pos_y;
   logic [sal_pkg::SIDE_W-1:0]   atlas_w;
   logic [sal_pkg::SIDE_W-1:0]   atlas_h;
   logic                         grew;
   modport source (output valid, placed, pos_x, pos_y, atlas_w, atlas_h, grew, input ready);
   modport sink (input valid, placed, pos_x, pos_y, atlas_w, atlas_h, grew, output ready);
endinterface

interface sal_csr_if;
   logic                         valid;
   logic                         ready;
   logic [sal_pkg::IDX_W-1:0]    reg_index;
   logic [sal_pkg::CFG_W-1:0]    wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: design/sal_ctrl.sv
// Sequencer of the allocator: accepts items, steps the datapath, hands off results.
// Depends on sal_pkg.
module sal_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  sal_pkg::status_type sts,
   output sal_pkg::cmd_type    cmd
);

   sal_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               send_free;

   assign send_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sal_pkg::ST_IDLE: begin
            if (req_valid) state_in = sal_pkg::ST_WORK;
         end
         sal_pkg::ST_WORK: begin
            if (sts.is_restart || sts.fits || (!sts.shelf_ok && !sts.grow_ok))
               state_in = sal_pkg::ST_SEND;
         end
         sal_pkg::ST_SEND: begin
            if (send_free) state_in = sal_pkg::ST_IDLE;
         end
         default: state_in = sal_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         sal_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         sal_pkg::ST_WORK: begin
            priority if (sts.is_restart) cmd.restart   = 1'b1;
            else if (sts.fits)           cmd.place     = 1'b1;
            else if (sts.shelf_ok)       cmd.new_shelf = 1'b1;
            else if (sts.grow_ok)        cmd.grow      = 1'b1;
            else                         cmd.fail      = 1'b1;
         end
         sal_pkg::ST_SEND: begin
            cmd.publish = send_free;
         end
         default: cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.publish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sal_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/sal_datapath.sv
// Datapath of the allocator: registers, shelf state, fit and growth checks,
// result register. Depends on sal_pkg.
module sal_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_kind,
   input  logic [sal_pkg::RECT_W-1:0]    req_rect_w,
   input  logic [sal_pkg::RECT_W-1:0]    req_rect_h,
   input  logic                          csr_write,
   input  logic [sal_pkg::IDX_W-1:0]     csr_reg_index,
   input  logic [sal_pkg::CFG_W-1:0]     csr_wdata,
   input  sal_pkg::cmd_type              cmd,
   output sal_pkg::status_type           sts,
   output logic                          rsp_placed,
   output logic [sal_pkg::POS_W-1:0]     rsp_pos_x,
   output logic [sal_pkg::POS_W-1:0]     rsp_pos_y,
   output logic [sal_pkg::SIDE_W-1:0]    rsp_atlas_w,
   output logic [sal_pkg::SIDE_W-1:0]    rsp_atlas_h,
   output logic                          rsp_grew
);

   localparam int SW = sal_pkg::SIDE_W;

   logic [sal_pkg::PAD_W-1:0] padding_ff;
   logic [sal_pkg::CFG_W-1:0] init_side_ff, max_side_ff;

   logic [SW-1:0] pen_x_ff, shelf_top_ff, shelf_h_ff, side_w_ff, side_h_ff;
   logic [SW-1:0] need_w_ff, need_h_ff, old_w_ff, old_h_ff;
   logic          kind_ff;
   logic          res_placed_ff;
   logic [SW-1:0] res_x_ff, res_y_ff;

   logic          out_placed_ff, out_grew_ff;
   logic [sal_pkg::POS_W-1:0] out_x_ff, out_y_ff;
   logic [SW-1:0] out_w_ff, out_h_ff;

   logic [SW-1:0] init_c, eff_init, max_c, eff_max;
   logic [SW:0]   pen_end, row_end;
   logic [SW+1:0] shelf_end;
   logic [SW-1:0] nw, nh, new_shelf_h;
   logic          at_max;

   // effective initial and maximum sides
   always_comb begin
      init_c   = SW'(init_side_ff);
      eff_init = (init_c < sal_pkg::MIN_V) ? sal_pkg::MIN_V : init_c;
      if (eff_init > sal_pkg::LIMIT_V) eff_init = sal_pkg::LIMIT_V;
      max_c    = SW'(max_side_ff);
      eff_max  = (max_c < eff_init) ? eff_init : max_c;
      if (eff_max > sal_pkg::LIMIT_V) eff_max = sal_pkg::LIMIT_V;
   end

   assign pen_end   = {1'b0, pen_x_ff} + {1'b0, need_w_ff};
   assign row_end   = {1'b0, shelf_top_ff} + {1'b0, need_h_ff};
   assign shelf_end = {2'b00, shelf_top_ff} + {2'b00, shelf_h_ff} + {2'b00, need_h_ff};

   always_comb begin
      at_max = (side_w_ff >= eff_max && side_h_ff >= eff_max) ||
               (side_w_ff >= sal_pkg::LIMIT_V && side_h_ff >= sal_pkg::LIMIT_V);
      nw = (side_w_ff <= side_h_ff && side_w_ff < eff_max) ?
           sal_pkg::doubled(side_w_ff) : side_w_ff;
      nh = (nw == side_w_ff) ? sal_pkg::doubled(side_h_ff) : side_h_ff;
   end

   assign new_shelf_h = (need_h_ff > shelf_h_ff) ? need_h_ff : shelf_h_ff;

   assign sts.is_restart = kind_ff;
   assign sts.fits       = (pen_end <= {1'b0, side_w_ff}) && (row_end <= {1'b0, side_h_ff});
   assign sts.shelf_ok   = (pen_x_ff != '0) && (need_w_ff <= side_w_ff) &&
                           (shelf_end <= {2'b00, side_h_ff});
   assign sts.grow_ok    = !at_max && ((nw != side_w_ff) || (nh != side_h_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         padding_ff   <= sal_pkg::PADDING_RST;
         init_side_ff <= sal_pkg::INIT_RST;
         max_side_ff  <= sal_pkg::MAX_RST;
      end else if (csr_write) begin
         unique case (csr_reg_index)
            sal_pkg::CSR_PADDING:      padding_ff   <= csr_wdata[sal_pkg::PAD_W-1:0];
            sal_pkg::CSR_INITIAL_SIDE: init_side_ff <= csr_wdata;
            sal_pkg::CSR_MAX_SIDE:     max_side_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= '0;
         shelf_top_ff <= '0;
         shelf_h_ff   <= '0;
         side_w_ff    <= sal_pkg::SIDE_RST;
         side_h_ff    <= sal_pkg::SIDE_RST;
      end else begin
         if (cmd.restart) begin
            pen_x_ff     <= '0;
            shelf_top_ff <= '0;
            shelf_h_ff   <= '0;
            side_w_ff    <= eff_init;
            side_h_ff    <= eff_init;
         end
         if (cmd.place) begin
            pen_x_ff   <= pen_end[SW-1:0];
            shelf_h_ff <= new_shelf_h;
         end
         if (cmd.new_shelf) begin
            shelf_top_ff <= shelf_top_ff + shelf_h_ff;
            pen_x_ff     <= '0;
            shelf_h_ff   <= '0;
         end
         if (cmd.grow) begin
            side_w_ff <= nw;
            side_h_ff <= nh;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         need_w_ff <= SW'(req_rect_w) + SW'(padding_ff);
         need_h_ff <= SW'(req_rect_h) + SW'(padding_ff);
         old_w_ff  <= side_w_ff;
         old_h_ff  <= side_h_ff;
      end
      if (cmd.place) begin
         res_placed_ff <= 1'b1;
         res_x_ff      <= pen_x_ff;
         res_y_ff      <= shelf_top_ff;
      end
      if (cmd.fail || cmd.restart) begin
         res_placed_ff <= 1'b0;
         res_x_ff      <= '0;
         res_y_ff      <= '0;
      end
      if (cmd.publish) begin
         out_placed_ff <= res_placed_ff;
         out_x_ff      <= res_x_ff[sal_pkg::POS_W-1:0];
         out_y_ff      <= res_y_ff[sal_pkg::POS_W-1:0];
         out_w_ff      <= side_w_ff;
         out_h_ff      <= side_h_ff;
         out_grew_ff   <= (side_w_ff != old_w_ff) || (side_h_ff != old_h_ff);
      end
   end

   assign rsp_placed  = out_placed_ff;
   assign rsp_pos_x   = out_x_ff;
   assign rsp_pos_y   = out_y_ff;
   assign rsp_atlas_w = out_w_ff;
   assign rsp_atlas_h = out_h_ff;
   assign rsp_grew    = out_grew_ff;

endmodule

FILE: design/shelf_atlas_allocator_unit.sv
// Top level of the shelf atlas allocator: sequencer plus datapath.
// Depends on sal_pkg, sal_channels, sal_ctrl, sal_datapath, assert_macros.svh.
//
// Usage:
//   req_chan carries one item: kind 0 allocates a rect_w x rect_h rectangle
//   (both grown by the padding register), kind 1 restarts the atlas.
//   rsp_chan returns exactly one result per item: placed, pos_x, pos_y,
//   atlas_w, atlas_h and grew. csr_chan writes padding (index 0),
//   initial_side (1) and max_side (2); it is always ready. It must be written
//   only while the block is idle; the block itself does not enforce this.
//   Sequence: after an item is accepted the sequencer works in steps (a
//   placement try, a new shelf, or one doubling of the atlas), then loads
//   the output register; each extra new shelf or doubling adds a step.
//   The next item is taken only after the result is loaded, so a new item
//   is not accepted before the last one is through.
//   A result waiting in the output register does not block the next item;
//   if rsp_ready stays low the following result waits in the sequencer.
//   Reset (synchronous): registers back to padding 1, initial 256, max 4096,
//   shelves cleared, atlas 256 x 256, no result pending.
`include "assert_macros.svh"

module shelf_atlas_allocator_unit (
   input  logic      clock,
   input  logic      reset,
   sal_req_if.sink   req_chan,
   sal_rsp_if.source rsp_chan,
   sal_csr_if.sink   csr_chan
);

   sal_pkg::cmd_type    cmd;
   sal_pkg::status_type sts;

   assign csr_chan.ready = 1'b1;

   sal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sal_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_kind      (req_chan.kind),
      .req_rect_w    (req_chan.rect_w),
      .req_rect_h    (req_chan.rect_h),
      .csr_write     (csr_chan.valid),
      .csr_reg_index (csr_chan.reg_index),
      .csr_wdata     (csr_chan.wdata),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_placed    (rsp_chan.placed),
      .rsp_pos_x     (rsp_chan.pos_x),
      .rsp_pos_y     (rsp_chan.pos_y),
      .rsp_atlas_w   (rsp_chan.atlas_w),
      .rsp_atlas_h   (rsp_chan.atlas_h),
      .rsp_grew      (rsp_chan.grew)
   );

   `SAL_ASSERT_IMPL(a_fail_zero_pos, clock, reset, rsp_chan.valid && !rsp_chan.placed, (rsp_chan.pos_x == '0) && (rsp_chan.pos_y == '0))
   `SAL_ASSERT_IMPL(a_pos_in_atlas, clock, reset, rsp_chan.valid && rsp_chan.placed, (rsp_chan.pos_x <= rsp_chan.atlas_w) && (rsp_chan.pos_y <= rsp_chan.atlas_h))
   `SAL_ASSERT_NEXT(a_busy_after_take, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)

endmodule

FILE: bench/sal_scoreboard.sv
`timescale 1ns / 1ps
// Shelf atlas allocator scoreboard: bench-side codes, a shelf packing predictor
// and a field-by-field compare of every result item. Depends on sal_pkg and sal_channels.
package sal_bench_pkg;

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   localparam logic [sal_pkg::IDX_W-1:0] CSR_SPARE = 2'd3;

endpackage

module sal_scoreboard (
   input  logic clock,
   input  logic reset,
   sal_req_if   req_bus,
   sal_rsp_if   rsp_bus,
   sal_csr_if   csr_bus,
   output int   errors,
   output int   waiting
);
   import sal_pkg::*;
   import sal_bench_pkg::*;

   typedef struct packed {
      logic              placed;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [SIDE_W-1:0] aw;
      logic [SIDE_W-1:0] ah;
      logic              grew;
   } slot_t;

   logic [PAD_W-1:0] pad;
   logic [CFG_W-1:0] init_cfg;
   logic [CFG_W-1:0] max_cfg;
   int unsigned      pen;
   int unsigned      top_row;
   int unsigned      row_h;
   int unsigned      wide;
   int unsigned      tall;
   slot_t            pending_placements[$];
   int               mismatches = 0;
   int               backlog = 0;

   assign errors  = mismatches;
   assign waiting = backlog;

   function automatic int unsigned base_side();
      int unsigned s;
      s = (init_cfg < MIN_SIDE) ? MIN_SIDE : init_cfg;
      return (s > SIDE_LIMIT) ? SIDE_LIMIT : s;
   endfunction

   function automatic int unsigned ceiling_side();
      int unsigned b, m;
      b = base_side();
      m = (max_cfg < b) ? b : max_cfg;
      return (m > SIDE_LIMIT) ? SIDE_LIMIT : m;
   endfunction

   function automatic int unsigned twice(int unsigned s);
      return (2 * s > SIDE_LIMIT) ? SIDE_LIMIT : 2 * s;
   endfunction

   // shorter side doubles first, width on a tie
   function automatic bit try_grow();
      int unsigned m, nw, nh;
      m = ceiling_side();
      if ((wide >= m && tall >= m) || (wide >= SIDE_LIMIT && tall >= SIDE_LIMIT))
         return 1'b0;
      nw = (wide <= tall && wide < m) ? twice(wide) : wide;
      nh = (nw == wide) ? twice(tall) : tall;
      if (nw == wide && nh == tall)
         return 1'b0;
      wide = nw;
      tall = nh;
      return 1'b1;
   endfunction

   function automatic bit fit_rect(input int unsigned need_w, need_h,
                                   output int unsigned px, py);
      px = 0;
      py = 0;
      while (1'b1) begin
         if (pen + need_w <= wide && top_row + need_h <= tall) begin
            px = pen;
            py = top_row;
            pen += need_w;
            if (need_h > row_h)
               row_h = need_h;
            return 1'b1;
         end
         if (pen != 0 && need_w <= wide && top_row + row_h + need_h <= tall) begin
            top_row += row_h;
            pen = 0;
            row_h = 0;
         end else if (!try_grow()) begin
            return 1'b0;
         end
      end
      return 1'b0;
   endfunction

   function automatic slot_t place_rect(logic kind, logic [RECT_W-1:0] w, h);
      slot_t       r;
      int unsigned old_w, old_h, need_w, need_h, px, py;
      bit          ok;
      old_w = wide;
      old_h = tall;
      px = 0;
      py = 0;
      ok = 1'b0;
      if (kind == KIND_RESTART) begin
         pen = 0;
         top_row = 0;
         row_h = 0;
         wide = base_side();
         tall = wide;
      end else begin
         need_w = w;
         need_w += pad;
         need_h = h;
         need_h += pad;
         ok = fit_rect(need_w, need_h, px, py);
         if (!ok) begin
            px = 0;
            py = 0;
         end
      end
      r.placed = ok;
      r.x      = px[POS_W-1:0];
      r.y      = py[POS_W-1:0];
      r.aw     = wide[SIDE_W-1:0];
      r.ah     = tall[SIDE_W-1:0];
      r.grew   = (wide != old_w || tall != old_h);
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 50)
         $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic check_field(string tag, int unsigned got, int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d want %0d", tag, got, want));
   endtask

   always @(posedge clock) begin
      slot_t got, want;
      if (reset) begin
         pad = PADDING_RST;
         init_cfg = INIT_RST;
         max_cfg = MAX_RST;
         pen = 0;
         top_row = 0;
         row_h = 0;
         wide = SIDE_RST;
         tall = SIDE_RST;
         pending_placements.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.reg_index)
               CSR_PADDING:      pad = csr_bus.wdata[PAD_W-1:0];
               CSR_INITIAL_SIDE: init_cfg = csr_bus.wdata;
               CSR_MAX_SIDE:     max_cfg = csr_bus.wdata;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            pending_placements.push_back(place_rect(req_bus.kind, req_bus.rect_w,
                                                    req_bus.rect_h));
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.placed = rsp_bus.placed;
            got.x      = rsp_bus.pos_x;
            got.y      = rsp_bus.pos_y;
            got.aw     = rsp_bus.atlas_w;
            got.ah     = rsp_bus.atlas_h;
            got.grew   = rsp_bus.grew;
            if (pending_placements.size() == 0) begin
               report_mismatch("result item with no prediction waiting");
            end else begin
               want = pending_placements.pop_front();
               check_field("placed", got.placed, want.placed);
               check_field("pos_x", got.x, want.x);
               check_field("pos_y", got.y, want.y);
               check_field("atlas_w", got.aw, want.aw);
               check_field("atlas_h", got.ah, want.ah);
               check_field("grew", got.grew, want.grew);
            end
         end
      end
      backlog <= pending_placements.size();
   end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Top of the shelf atlas allocator bench: clock, reset, stimulus and verdict.
// Depends on sal_pkg, sal_channels, the allocator RTL and sal_scoreboard.
module tb;
   import sal_pkg::*;
   import sal_bench_pkg::*;

   typedef enum int { RX_STEADY, RX_COIN, RX_LONG } rx_mode_t;

   localparam int CYCLE_LIMIT = 600000;

   logic        clock;
   logic        reset;
   int          errors;
   int          waiting;
   int          cycles = 0;
   rx_mode_t    stall_mode = RX_STEADY;
   int unsigned gap_max = 0;

   sal_req_if req_bus ();
   sal_rsp_if rsp_bus ();
   sal_csr_if csr_bus ();

   shelf_atlas_allocator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   sal_scoreboard board (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .errors  (errors),
      .waiting (waiting)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int   run;
      logic take;
      run = 0;
      take = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (run == 0) begin
            case (stall_mode)
               RX_STEADY: begin
                  take = 1'b1;
                  run = $urandom_range(1, 16);
               end
               RX_COIN: begin
                  take = 1'($urandom_range(0, 1));
                  run = 1;
               end
               default: begin
                  take = ~take;
                  run = take ? $urandom_range(1, 6) : $urandom_range(1, 20);
               end
            endcase
            rsp_bus.ready <= take;
         end
         run--;
      end
   end

   task automatic send_item(logic k, logic [RECT_W-1:0] w, logic [RECT_W-1:0] h);
      req_bus.valid  <= 1'b1;
      req_bus.kind   <= k;
      req_bus.rect_w <= w;
      req_bus.rect_h <= h;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata     <= data;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
   endtask

   task automatic set_config(logic [CFG_W-1:0] p, logic [CFG_W-1:0] i, logic [CFG_W-1:0] m);
      write_reg(CSR_PADDING, p);
      write_reg(CSR_INITIAL_SIDE, i);
      write_reg(CSR_MAX_SIDE, m);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0)
         @(posedge clock);
   endtask

   // mostly small rectangles so shelves fill before the atlas maxes out
   function automatic logic [RECT_W-1:0] pick_extent();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return RECT_W'($urandom_range(1, 32));
      else if (r < 88)
         return RECT_W'($urandom_range(1, 256));
      else if (r < 97)
         return RECT_W'($urandom_range(1, 4096));
      return RECT_W'($urandom_range(0, 16383));
   endfunction

   task automatic run_phase(int count);
      int left, burst, gap;
      send_item(KIND_RESTART, pick_extent(), pick_extent());
      left = count - 1;
      while (left > 0) begin
         burst = $urandom_range(1, 12);
         if (burst > left)
            burst = left;
         repeat (burst) begin
            if ($urandom_range(0, 24) == 0)
               send_item(KIND_RESTART, pick_extent(), pick_extent());
            else
               send_item(KIND_ALLOC, pick_extent(), pick_extent());
         end
         left -= burst;
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      int unsigned pad_v, init_v, max_v;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_ALLOC;
      req_bus.rect_w = '0;
      req_bus.rect_h = '0;
      csr_bus.valid = 1'b0;
      csr_bus.reg_index = CSR_PADDING;
      csr_bus.wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: fit, oversize fail after growth, restart, growth, new shelf
      stall_mode = RX_COIN;
      send_item(KIND_ALLOC, 14'd1, 14'd1);
      send_item(KIND_ALLOC, 14'd16383, 14'd1);
      send_item(KIND_RESTART, 14'd16383, 14'd16383);
      send_item(KIND_ALLOC, 14'd300, 14'd10);
      send_item(KIND_ALLOC, 14'd300, 14'd10);
      send_item(KIND_ALLOC, 14'd1, 14'd16383);

      // smallest settings: clamped sides, zero-size rect, full atlas
      drain();
      write_reg(CSR_SPARE, 14'h2AAA);
      set_config(14'd0, 14'd0, 14'd0);
      send_item(KIND_RESTART, 14'd0, 14'd0);
      send_item(KIND_ALLOC, 14'd0, 14'd0);
      send_item(KIND_ALLOC, 14'd16, 14'd16);
      send_item(KIND_ALLOC, 14'd1, 14'd1);

      // largest settings: oversize fail with no growth at max_side, then new shelf
      drain();
      set_config(14'h3FFF, 14'd16383, 14'd16383);
      send_item(KIND_RESTART, 14'd1, 14'd1);
      send_item(KIND_ALLOC, 14'd16383, 14'd16383);
      send_item(KIND_ALLOC, 14'd1, 14'd1);
      send_item(KIND_ALLOC, 14'd16127, 14'd1);

      // odd sizes: growth past max_side, growth then new shelf
      drain();
      set_config(14'd7, 14'd40, 14'd100);
      send_item(KIND_RESTART, 14'd0, 14'd0);
      send_item(KIND_ALLOC, 14'd50, 14'd5);
      send_item(KIND_ALLOC, 14'd60, 14'd60);
      send_item(KIND_ALLOC, 14'd60, 14'd60);
      send_item(KIND_ALLOC, 14'd8192, 14'd8192);

      for (int phase = 0; phase < 10; phase++) begin
         drain();
         case (phase)
            0: set_config(14'd1, 14'd256, 14'd4096);
            1: set_config(14'd0, 14'd0, 14'd0);
            2: set_config(14'd255, 14'd16383, 14'd16383);
            default: begin
               pad_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 3);
               init_v = $urandom_range(0, 600);
               max_v = $urandom_range(0, 3000);
               set_config(CFG_W'(pad_v), CFG_W'(init_v), CFG_W'(max_v));
            end
         endcase
         stall_mode = rx_mode_t'($urandom_range(0, 2));
         gap_max = (phase % 4 == 0) ? 0 : $urandom_range(1, 8);
         run_phase(125);
      end

      drain();
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/sal_pkg.sv
design/sal_channels.sv
design/sal_ctrl.sv
design/sal_datapath.sv
design/shelf_atlas_allocator_unit.sv
bench/sal_scoreboard.sv
bench/tb.sv
